// File: sv/lpcd_pkg.sv
package lpcd_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 1024;
  localparam int unsigned MIN_FRAME_BYTES = 5;
  localparam int unsigned SHORT_LEN_MAX   = 2;

  localparam logic [15:0] MaxLen = 16'(MAX_FRAME_BYTES);
  localparam logic [15:0] MinLen = 16'(MIN_FRAME_BYTES);
  localparam logic [15:0] ShortLenMax = 16'(SHORT_LEN_MAX);

  // Configuration register indexes.
  localparam logic CFG_CHECK_RESPONSE   = 1'b0;
  localparam logic CFG_EXPECTED_COMMAND = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UNDERSIZED = 3'd1,
    ST_OVERSIZED  = 3'd2,
    ST_BAD_CRC    = 3'd3,
    ST_BAD_CMD    = 3'd4
  } status_t;

  // Packed so that the status lands in the lowest bits.
  typedef struct packed {
    logic [15:0] frame_length;
    logic [7:0]  frame_command;
    status_t     frame_status;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);
  localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

  // CRC-16/XMODEM, one byte, table-free form.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = {crc[7:0], crc[15:8]};
    c = c ^ {8'h00, b};
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

endpackage

// File: sv/length_prefixed_crc16_deframer_core.sv
// A frame's result enters the output register, or the skid register if the output one is held.
// Throughput: one byte per cycle when not stalled; CRC update, counters and checks are combinational.
// The input stalls only when both the output register and the skid register hold results.
// Reset: synchronous, active low; clears the frame state, the buffer and both config registers.
module length_prefixed_crc16_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  // Received byte stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // Frame results.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [lpcd_pkg::OUT_TDATA_W-1:0] out_tdata
  // [2:0] frame_status, [10:3] frame_command, [26:11] frame_length, rest zero
);
  import lpcd_pkg::*;

  logic    in_xfer;
  logic    res_valid;
  result_t res_data;
  logic    buf_space;
  result_t out_res;

  // A byte transfers whenever the skid register is free, so the frame
  // logic never has to hold back a result it produces.
  assign in_tready = buf_space;
  assign in_xfer   = in_tvalid && in_tready;

  // Frame tracker: length capture, CRC with two-byte hold-back and checks.
  lpcd_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .byte_valid (in_xfer),
    .byte_data  (in_tdata),
    .res_valid  (res_valid),
    .res_data   (res_data)
  );

  // Output register with a skid stage behind it.
  lpcd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res_data),
    .space     (buf_space),
    .out_valid (out_tvalid),
    .out_data  (out_res),
    .out_ready (out_tready)
  );

  assign out_tdata = OUT_TDATA_W'(out_res);

endmodule

// File: sv/lpcd_frame.sv
module lpcd_frame (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [7:0]              cfg_wdata,
  input  logic                    byte_valid,
  input  logic [7:0]              byte_data,
  output logic                    res_valid,
  output lpcd_pkg::result_t       res_data
);
  import lpcd_pkg::*;

  typedef enum logic [2:0] {
    PH_LEN_HI = 3'b001,
    PH_LEN_LO = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] byte_index_r, byte_index_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  command_r, command_nxt;
  logic [15:0] held_r, held_nxt;
  logic        check_r;
  logic [7:0]  expected_r;
  logic        emit;

  always_comb begin
    phase_nxt      = phase_r;
    byte_index_nxt = byte_index_r;
    length_nxt     = length_r;
    crc_nxt        = crc_r;
    command_nxt    = command_r;
    held_nxt       = held_r;
    emit           = 1'b0;
    if (byte_valid) begin
      unique case (phase_r)
        PH_LEN_LO: begin
          length_nxt     = length_r | {8'h00, byte_data};
          held_nxt       = {held_r[7:0], byte_data};
          byte_index_nxt = 16'd2;
          if (length_nxt <= ShortLenMax) begin
            emit      = 1'b1;
            phase_nxt = PH_LEN_HI;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          crc_nxt  = crc16_byte(crc_r, held_r[15:8]);
          held_nxt = {held_r[7:0], byte_data};
          if (byte_index_r == 16'd2) begin
            command_nxt = byte_data;
          end
          byte_index_nxt = byte_index_r + 16'd1;
          if (byte_index_nxt == length_r) begin
            emit      = 1'b1;
            phase_nxt = PH_LEN_HI;
          end
        end
        default: begin
          length_nxt     = {byte_data, 8'h00};
          held_nxt       = {8'h00, byte_data};
          byte_index_nxt = 16'd1;
          crc_nxt        = 16'd0;
          command_nxt    = 8'd0;
          phase_nxt      = PH_LEN_LO;
        end
      endcase
    end
  end

  // Status checks run on the updated state, first failing check wins.
  always_comb begin
    res_data.frame_length  = length_nxt;
    res_data.frame_command = command_nxt;
    priority if (length_nxt < MinLen) begin
      res_data.frame_status  = ST_UNDERSIZED;
      res_data.frame_command = 8'd0;
    end else if (length_nxt > MaxLen) begin
      res_data.frame_status = ST_OVERSIZED;
    end else if (crc_nxt != held_nxt) begin
      res_data.frame_status = ST_BAD_CRC;
    end else if (check_r && (command_nxt != expected_r)) begin
      res_data.frame_status = ST_BAD_CMD;
    end else begin
      res_data.frame_status = ST_OK;
    end
  end

  assign res_valid = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEN_HI;
      byte_index_r <= '0;
      length_r     <= '0;
      crc_r        <= '0;
      command_r    <= '0;
      held_r       <= '0;
      check_r      <= 1'b0;
      expected_r   <= '0;
    end else begin
      phase_r      <= phase_nxt;
      byte_index_r <= byte_index_nxt;
      length_r     <= length_nxt;
      crc_r        <= crc_nxt;
      command_r    <= command_nxt;
      held_r       <= held_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CHECK_RESPONSE:   check_r    <= cfg_wdata[0];
          CFG_EXPECTED_COMMAND: expected_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: sv/lpcd_outbuf.sv
module lpcd_outbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lpcd_pkg::result_t    push_data,
  output logic                 space,
  output logic                 out_valid,
  output lpcd_pkg::result_t    out_data,
  input  logic                 out_ready
);
  import lpcd_pkg::*;

  logic    main_valid_r, skid_valid_r;
  result_t main_r, skid_r;
  logic    pop;

  assign pop       = main_valid_r && out_ready;
  assign space     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end
  end

endmodule

// File: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lpcd_pkg::*;

  // Polynomial of CRC-16/XMODEM, processed MSB first with no reflection.
  localparam logic [15:0] CRC_POLY = 16'h1021;
  // Cycles allowed after the last result before a register write or the end.
  localparam int unsigned SETTLE_CYCLES = 4;
  // Bytes of random traffic sent under each register setting.
  localparam int unsigned ROUND_BYTES = 80;
  localparam int unsigned NUM_ROUNDS = 6;
  localparam int unsigned MAX_REPORTED = 10;

  // Phases of the deframer as the predictor tracks them.
  typedef enum logic [2:0] {
    PH_LEN_HI = 3'b001,
    PH_LEN_LO = 3'b010,
    PH_BODY   = 3'b100
  } deframe_phase_t;

  // One frame report as the block should deliver it.
  typedef struct {
    status_t     status;
    logic [7:0]  command;
    logic [15:0] length;
  } frame_report_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [7:0] cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  length_prefixed_crc16_deframer_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Reports still owed by the block, oldest first.
  frame_report_t pending_reports[$];
  int unsigned   fail_count;
  int unsigned   bytes_accepted;

  // Random idle cycles on either side can be switched off to get stretches
  // where bytes and results move on every cycle.
  bit sender_gaps_on;
  bit receiver_stalls_on;

  // Shadow of the two configuration registers.
  bit         check_cmd_on;
  logic [7:0] awaited_cmd;

  // Frame tracker state, mirroring what the deframer holds.
  deframe_phase_t trk_phase;
  logic [15:0]    trk_index;
  logic [15:0]    trk_length;
  logic [15:0]    trk_crc;
  logic [7:0]     trk_cmd;
  logic [15:0]    trk_held;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run. The slowest legal run (every byte and every
  // result behind the longest random gap) is far shorter.
  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Bitwise CRC-16/XMODEM update over one byte.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTED) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  // The status priority is undersized, then oversized, then a CRC mismatch,
  // and only then a wrong command when command checking is enabled.
  function automatic void queue_report();
    frame_report_t r;
    r.command = trk_cmd;
    r.length  = trk_length;
    if (trk_length < MinLen) begin
      r.status  = ST_UNDERSIZED;
      r.command = 8'h00;
    end else if (trk_length > MaxLen) begin
      r.status = ST_OVERSIZED;
    end else if (trk_crc != trk_held) begin
      r.status = ST_BAD_CRC;
    end else if (check_cmd_on && trk_cmd != awaited_cmd) begin
      r.status = ST_BAD_CMD;
    end else begin
      r.status = ST_OK;
    end
    pending_reports.push_back(r);
  endfunction

  // Advances the frame tracker by one accepted byte. The last two bytes are
  // held back, so a byte enters the CRC only once two newer bytes arrived;
  // at the frame end the held pair is the received CRC.
  function automatic void track_byte(input logic [7:0] b);
    unique case (trk_phase)
      PH_LEN_LO: begin
        trk_length = trk_length | {8'h00, b};
        trk_held   = {trk_held[7:0], b};
        trk_index  = 16'd2;
        // Lengths that do not even cover the length field end the frame here.
        if (trk_length <= ShortLenMax) begin
          queue_report();
          trk_phase = PH_LEN_HI;
        end else begin
          trk_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        trk_crc  = crc16_update(trk_crc, trk_held[15:8]);
        trk_held = {trk_held[7:0], b};
        if (trk_index == 16'd2) begin
          trk_cmd = b;
        end
        trk_index = trk_index + 16'd1;
        if (trk_index == trk_length) begin
          queue_report();
          trk_phase = PH_LEN_HI;
        end
      end
      default: begin
        trk_length = {b, 8'h00};
        trk_held   = {8'h00, b};
        trk_index  = 16'd1;
        trk_crc    = 16'h0000;
        trk_cmd    = 8'h00;
        trk_phase  = PH_LEN_LO;
      end
    endcase
  endfunction

  // Sends one byte: an optional random gap, then valid is held until the
  // transfer. Every call starts just after a rising edge, so valid stays
  // high across back-to-back bytes without being dropped in between.
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    gap = sender_gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_accepted++;
    track_byte(b);
  endtask

  // Builds and sends one frame. The CRC covers every byte before the CRC
  // field. A noise frame keeps its length field but fills the rest at random.
  task automatic send_frame(input logic [15:0] len, input logic [7:0] cmd,
                            input bit good_crc, input bit noise);
    int unsigned n;
    logic [15:0] crc;
    logic [7:0]  b;
    n   = (len <= ShortLenMax) ? 2 : len;
    crc = 16'h0000;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 0) begin
        b = len[15:8];
      end else if (i == 1) begin
        b = len[7:0];
      end else if (noise) begin
        b = 8'($urandom_range(0, 255));
      end else if (i == 2) begin
        b = cmd;
      end else if (i + 2 < n) begin
        b = 8'($urandom_range(0, 255));
      end else if (i + 2 == n) begin
        b = crc[15:8];
      end else begin
        b = good_crc ? crc[7:0] : crc[7:0] ^ 8'($urandom_range(1, 255));
      end
      if (i + 2 < n) begin
        crc = crc16_update(crc, b);
      end
      push_byte(b);
    end
  endtask

  // Stops sending and waits until every owed report has come back, then
  // waits out SETTLE_CYCLES so that the block is idle before any register write.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CHECK_RESPONSE) begin
      check_cmd_on = data[0];
    end else begin
      awaited_cmd = data;
    end
  endtask

  // Lengths 0 to 2 take just the two length bytes; 3 and 4 take exactly that
  // many bytes. All of them are reported undersized with command zero.
  task automatic test_short_frames();
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h01);
    push_byte(8'h00);
    push_byte(8'h02);
    push_byte(8'h00);
    push_byte(8'h03);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h04);
    push_byte(8'hFF);
    push_byte(8'h00);
    wait_drained();
  endtask

  // Smallest valid frame, once with a good and once with a broken CRC.
  task automatic test_min_frames();
    send_frame(MinLen, 8'hFF, 1'b1, 1'b0);
    send_frame(MinLen, 8'h00, 1'b0, 1'b0);
    wait_drained();
  endtask

  // Command checking, its place in the status order, and both extremes of
  // the awaited command.
  task automatic test_command_check();
    cfg_write(CFG_CHECK_RESPONSE, 8'h01);
    cfg_write(CFG_EXPECTED_COMMAND, 8'h5A);
    send_frame(16'd8, 8'h5A, 1'b1, 1'b0);
    send_frame(16'd8, 8'h5B, 1'b1, 1'b0);
    send_frame(16'd8, 8'h5B, 1'b0, 1'b0);
    send_frame(16'd4, 8'h5B, 1'b1, 1'b0);
    // A matched command does not change what is awaited next.
    send_frame(16'd6, 8'h5A, 1'b1, 1'b0);
    wait_drained();
    cfg_write(CFG_EXPECTED_COMMAND, 8'hFF);
    send_frame(16'd6, 8'hFF, 1'b1, 1'b0);
    send_frame(16'd6, 8'h00, 1'b1, 1'b0);
    wait_drained();
    cfg_write(CFG_EXPECTED_COMMAND, 8'h00);
    send_frame(16'd6, 8'h00, 1'b1, 1'b0);
    send_frame(16'd6, 8'hFF, 1'b1, 1'b0);
    wait_drained();
    cfg_write(CFG_CHECK_RESPONSE, 8'h00);
    send_frame(16'd6, 8'h33, 1'b1, 1'b0);
    wait_drained();
  endtask

  // Largest accepted frame and the first oversized length. Oversized frames
  // are still consumed in full and report the command they carried, even
  // when the command check would also fail.
  task automatic test_size_limits();
    send_frame(MaxLen, 8'($urandom_range(0, 255)), 1'b1, 1'b0);
    wait_drained();
    cfg_write(CFG_CHECK_RESPONSE, 8'h01);
    cfg_write(CFG_EXPECTED_COMMAND, 8'h11);
    send_frame(MaxLen + 16'd1, 8'h22, 1'b1, 1'b0);
    wait_drained();
    cfg_write(CFG_CHECK_RESPONSE, 8'h00);
  endtask

  // Mostly well-formed frames with random content under several register
  // settings, mixed with short lengths, corrupted CRCs and random noise.
  task automatic test_random_frames();
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  cmd;
    for (int unsigned round = 0; round < NUM_ROUNDS; round++) begin
      unique case (round)
        0: begin
          cfg_write(CFG_CHECK_RESPONSE, 8'h00);
          cfg_write(CFG_EXPECTED_COMMAND, 8'($urandom_range(0, 255)));
        end
        1: begin
          cfg_write(CFG_CHECK_RESPONSE, 8'h01);
          cfg_write(CFG_EXPECTED_COMMAND, 8'($urandom_range(0, 255)));
        end
        2: cfg_write(CFG_EXPECTED_COMMAND, 8'h00);
        3: cfg_write(CFG_EXPECTED_COMMAND, 8'hFF);
        4: cfg_write(CFG_CHECK_RESPONSE, 8'h00);
        default: begin
          cfg_write(CFG_CHECK_RESPONSE, 8'h01);
          cfg_write(CFG_EXPECTED_COMMAND, 8'($urandom_range(0, 255)));
        end
      endcase
      sender_gaps_on     = (round % 3 != 2);
      receiver_stalls_on = (round % 3 != 1);
      start = bytes_accepted;
      while (bytes_accepted - start < ROUND_BYTES) begin
        pick = $urandom_range(0, 99);
        cmd  = ($urandom_range(0, 1) != 0) ? awaited_cmd : 8'($urandom_range(0, 255));
        if (pick < 8) begin
          send_frame(16'($urandom_range(0, 4)), cmd, 1'b1, 1'b0);
        end else if (pick < 16) begin
          send_frame(16'($urandom_range(0, 40)), cmd, 1'b0, 1'b1);
        end else begin
          len = $urandom_range(MinLen, 24);
          send_frame(16'(len), cmd, ($urandom_range(0, 9) != 0), 1'b0);
        end
        // Now and then the sender holds off until all reports are back.
        if (pick == 99) begin
          wait_drained();
        end
      end
      wait_drained();
    end
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
  endtask

  // Receiver side: a random stall before each result, then ready stays high
  // until a transfer happens.
  initial begin
    int unsigned stall;
    out_tready <= 1'b0;
    forever begin
      stall = receiver_stalls_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Every result transfer is matched against the oldest owed report. The
  // unused top bits of the data word must read zero.
  always @(posedge clk) begin : check_results
    frame_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        note_failure($sformatf("result with none owed: tdata=%h", out_tdata));
      end else begin
        want = pending_reports.pop_front();
        if (out_tdata[2:0] !== want.status || out_tdata[10:3] !== want.command ||
            out_tdata[26:11] !== want.length || out_tdata[OUT_TDATA_W-1:27] !== '0) begin
          note_failure($sformatf(
              "status/cmd/len expected %0d/%h/%h, got %0d/%h/%h (tdata=%h)",
              want.status, want.command, want.length,
              out_tdata[2:0], out_tdata[10:3], out_tdata[26:11], out_tdata));
        end
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_CHECK_RESPONSE;
    cfg_wdata <= 8'h00;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
    fail_count     = 0;
    bytes_accepted = 0;
    // Tracker and register shadow start from the reset state of the block.
    check_cmd_on = 1'b0;
    awaited_cmd  = 8'h00;
    trk_phase    = PH_LEN_HI;
    trk_index    = 16'h0000;
    trk_length   = 16'h0000;
    trk_crc      = 16'h0000;
    trk_cmd      = 8'h00;
    trk_held     = 16'h0000;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_frames();
    test_min_frames();
    test_command_check();
    test_size_limits();
    test_random_frames();

    // The last test leaves nothing owed; a late or extra result would still
    // be caught by the checker during the settle cycles.
    wait_drained();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
